>>> hdl/tncc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tncc_pkg: shared types and constants of the token classifier
// Centroid table, radii, feature widths and the front-end handoff struct.
// ----------------------------------------------------------------------------
package tncc_pkg;

  localparam int MaxGoals   = 16;
  localparam int CountLimit = 255;
  localparam int CntW       = 8;
  localparam int GoalW      = 5;
  localparam int NumCent    = 11;
  localparam int NumFeat    = 8;
  localparam int FeatW      = 17;   // 0..65536
  localparam int DistW      = 37;   // 8 * (2^17)^2 fits
  localparam logic [15:0] HashBasis = 16'h2325;
  localparam logic [15:0] HashPrime = 16'h01b3;
  localparam logic [DistW-1:0] RadSq050 = 37'd1073741824;
  localparam logic [DistW-1:0] RadSq045 = 37'd869730877;

  typedef logic [FeatW-1:0] feat_t;
  typedef logic [CntW-1:0]  cnt_t;

  // token summary handed from the front end to the classifier
  typedef struct packed {
    cnt_t        length;
    cnt_t        vowels;
    cnt_t        consonants;
    cnt_t        digits;
    cnt_t        others;
    logic [15:0] head_hash;
    logic [15:0] tail_hash;
  } token_sum_t;

  function automatic logic [15:0] hash_step(input logic [15:0] h, input logic [7:0] c);
    logic [31:0] p;
    p = 32'(h ^ {8'd0, c}) * 32'(HashPrime);
    return p[15:0];
  endfunction

  function automatic feat_t centroid(input logic [3:0] k, input logic [2:0] f);
    feat_t t [0:NumCent-1][0:NumFeat-1];
    t[0]  = '{19661, 21627, 32768, 0, 0, 0,    29491, 39322};
    t[1]  = '{19661, 19005, 28180, 0, 0, 0,    32768, 36045};
    t[2]  = '{19661, 21627, 32768, 0, 0, 0,    16384, 26214};
    t[3]  = '{22938, 19005, 37356, 0, 0, 0,    19661, 29491};
    t[4]  = '{22938, 28180, 28180, 0, 0, 0,    36045, 32768};
    t[5]  = '{19661, 21627, 32768, 0, 0, 0,    22938, 42598};
    t[6]  = '{19661, 19005, 28180, 0, 0, 9175, 26214, 32768};
    t[7]  = '{13107, 16384, 32768, 0, 0, 0,    39322, 19661};
    t[8]  = '{13107, 16384, 32768, 0, 0, 0,    36045, 29491};
    t[9]  = '{19661, 21627, 32768, 0, 0, 0,    16384, 22938};
    t[10] = '{22938, 19005, 28180, 0, 0, 9175, 29491, 36045};
    if (k < 4'(NumCent)) return t[k][f];
    return '0;
  endfunction

  function automatic logic [DistW-1:0] radius_sq(input logic [3:0] k);
    if (k == 4'd2 || k == 4'd9 || k == 4'd10) return RadSq045;
    return RadSq050;
  endfunction

endpackage
`default_nettype wire

>>> hdl/tncc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tncc_if: valid/ready channel carrying one beat of a given payload type
// Source drives valid and data, sink drives ready.
// ----------------------------------------------------------------------------
interface tncc_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/tncc_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tncc_divider: shared restoring divider, one quotient bit per cycle
// Divides a 25-bit numerator by a 17-bit divisor; quotient 25 bits.
// ----------------------------------------------------------------------------
module tncc_divider
  import tncc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [24:0] num,
  input  wire logic [16:0] den,
  output logic             done,
  output logic [24:0]      quot
);
  logic [24:0] shreg;
  logic [17:0] rem;
  logic [16:0] dreg;
  logic [4:0]  cnt;
  logic        busy;
  logic [17:0] trial;
  logic [17:0] diff;

  assign trial = {rem[16:0], shreg[24]};
  assign diff  = trial - {1'b0, dreg};

  // one restoring step a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd25;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= num;
      dreg  <= den;
      rem   <= '0;
    end else if (busy) begin
      if (!diff[17]) begin
        rem   <= diff;
        shreg <= {shreg[23:0], 1'b1};
      end else begin
        rem   <= trial;
        shreg <= {shreg[23:0], 1'b0};
      end
    end
  end

  assign quot = shreg;
endmodule
`default_nettype wire

>>> hdl/tncc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tncc_front: per-byte tokenizer and counters
// Lowercases, updates counts and hashes, reports a finished token.
// ----------------------------------------------------------------------------
module tncc_front
  import tncc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] text_byte,
  input  wire logic       end_of_text,
  output logic            tok_done,
  output token_sum_t      tok
);
  cnt_t        len, vow, con, dig, oth;
  logic [15:0] head;
  logic [23:0] tail;
  logic [7:0]  c;
  logic        is_tok, is_vow, is_let, is_dig;
  cnt_t        len_n, vow_n, con_n, dig_n, oth_n;
  logic [15:0] head_n, th;
  logic [23:0] tail_n;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v >= cnt_t'(CountLimit)) ? cnt_t'(CountLimit) : v + cnt_t'(1);
  endfunction

  // classify byte and compute token state after it
  always_comb begin
    c = (text_byte >= 8'h41 && text_byte <= 8'h5a) ? text_byte + 8'd32 : text_byte;
    is_let = c >= 8'h61 && c <= 8'h7a;
    is_dig = c >= 8'h30 && c <= 8'h39;
    is_tok = is_let || is_dig || c == 8'h5f;
    is_vow = c == 8'h61 || c == 8'h65 || c == 8'h69 || c == 8'h6f || c == 8'h75;
    len_n = len; vow_n = vow; con_n = con; dig_n = dig; oth_n = oth;
    head_n = head; tail_n = tail;
    if (is_tok) begin
      if (len < 8'd3) head_n = hash_step(head, c);
      tail_n = {tail[15:0], c};
      len_n = sat_inc(len);
      if (is_vow) vow_n = sat_inc(vow);
      else if (is_let) con_n = sat_inc(con);
      else if (is_dig) dig_n = sat_inc(dig);
      else oth_n = sat_inc(oth);
    end
    // tail hash over last min(len,3) chars, oldest first
    th = HashBasis;
    if (len_n >= 8'd3) th = hash_step(th, tail_n[23:16]);
    if (len_n >= 8'd2) th = hash_step(th, tail_n[15:8]);
    if (len_n >= 8'd1) th = hash_step(th, tail_n[7:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0; vow <= '0; con <= '0; dig <= '0; oth <= '0;
      head <= HashBasis; tail <= '0;
      tok_done <= 1'b0;
    end else begin
      tok_done <= 1'b0;
      if (step) begin
        if ((!is_tok || end_of_text) && len_n != '0) begin
          tok_done <= 1'b1;
          tok <= '{len_n, vow_n, con_n, dig_n, oth_n, head_n, th};
        end
        if (!is_tok || end_of_text) begin
          len <= '0; vow <= '0; con <= '0; dig <= '0; oth <= '0;
          head <= HashBasis; tail <= '0;
        end else begin
          len <= len_n; vow <= vow_n; con <= con_n; dig <= dig_n; oth <= oth_n;
          head <= head_n; tail <= tail_n;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/token_nearest_centroid_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// token_nearest_centroid_classifier: byte tokenizer with centroid classifier
// Tokenizes text, builds eight UQ1.16 features and picks the nearest centroid.
// ----------------------------------------------------------------------------
// A byte that does not close a token is taken in the accept cycle and
// then the token state sees whether it closed a token. A byte that closes a
// token runs five divisions (length scale and four ratios) on one shared
// serial divider, then the distance accumulation (one squared difference a
// cycle through one shared multiplier). The two hash features need no
// division. No new byte is taken before the output state is left. A result
// waits in an output register and bytes keep coming in meanwhile; only a
// second result stalls in the output state until that register is free.
module token_nearest_centroid_classifier
  import tncc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  tncc_if.sink      in_ch,
  tncc_if.source    out_ch
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_TOK = 6'b000010, S_DIV = 6'b000100,
    S_DWAIT = 6'b001000, S_DIST = 6'b010000, S_OUT = 6'b100000
  } state_t;

  state_t      state;
  logic        step, last, tok_done;
  token_sum_t  tok;
  feat_t       feat [0:NumFeat-1];
  logic [2:0]  di;           // division index 0..4
  logic        dstart, ddone;
  logic [24:0] dnum, dquot;
  logic [16:0] dden;
  logic [3:0]  k;
  logic [2:0]  f;
  logic [DistW-1:0] acc, best_d;
  logic [4:0]  best;
  logic [GoalW-1:0] goals;
  logic [17:0] sqd;
  logic [35:0] sq;
  logic [DistW-1:0] acc_n;
  feat_t       cf;
  logic        emit;

  assign in_ch.ready = (state == S_IDLE);
  assign step = in_ch.valid && in_ch.ready;

  tncc_front u_front (
    .clk(clk), .rst(rst), .step(step),
    .text_byte(in_ch.data.text_byte), .end_of_text(in_ch.data.end_of_text),
    .tok_done(tok_done), .tok(tok)
  );

  // division operands: length/20, then the four ratios
  always_comb begin
    dnum = '0; dden = 17'd1;
    case (di)
      3'd0: begin dnum = 25'({tok.length, 16'd0}) + 25'd10; dden = 17'd20; end
      3'd1: begin
        dnum = 25'({tok.vowels, 16'd0}) + 25'(tok.length >> 1); dden = 17'(tok.length);
      end
      3'd2: begin
        dnum = 25'({tok.consonants, 16'd0}) + 25'(tok.length >> 1); dden = 17'(tok.length);
      end
      3'd3: begin
        dnum = 25'({tok.digits, 16'd0}) + 25'(tok.length >> 1); dden = 17'(tok.length);
      end
      3'd4: begin
        dnum = 25'({tok.others, 16'd0}) + 25'(tok.length >> 1); dden = 17'(tok.length);
      end
      default: begin dnum = '0; dden = 17'd1; end
    endcase
  end

  tncc_divider u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quot(dquot)
  );

  // squared difference of one feature
  always_comb begin
    cf  = centroid(k, f);
    sqd = (feat[f] > cf) ? 18'(feat[f] - cf) : 18'(cf - feat[f]);
    sq  = 36'(sqd) * 36'(sqd);
    acc_n = acc + DistW'(sq);
  end

  assign dstart = (state == S_DIV);

  // a classified token under the goal limit, output register free
  assign emit = (state == S_OUT) && (!out_ch.valid || out_ch.ready) &&
                !best[4] && goals < GoalW'(MaxGoals - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_ch.valid <= 1'b0;
      goals <= '0;
      last <= 1'b0;
      di <= '0; k <= '0; f <= '0;
    end else begin
      if (emit) out_ch.valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: if (step) begin
          last <= in_ch.data.end_of_text;
          state <= S_TOK;
        end
        S_TOK: begin
          di <= '0;
          if (tok_done) begin
            // uppercase ratio is always zero; hash scale h*65536/65535
            // rounds to h, plus one for h >= 32768
            feat[3] <= '0;
            feat[6] <= feat_t'(tok.head_hash) + feat_t'(tok.head_hash[15]);
            feat[7] <= feat_t'(tok.tail_hash) + feat_t'(tok.tail_hash[15]);
            state <= S_DIV;
          end else begin
            if (last) goals <= '0;
            state <= S_IDLE;
          end
        end
        S_DIV: state <= S_DWAIT;
        S_DWAIT: if (ddone) begin
          case (di)
            3'd0: feat[0] <= (dquot > 25'd65536) ? 17'd65536 : dquot[16:0];
            3'd1: feat[1] <= dquot[16:0];
            3'd2: feat[2] <= dquot[16:0];
            3'd3: feat[4] <= dquot[16:0];
            default: feat[5] <= dquot[16:0];
          endcase
          if (di == 3'd4) begin
            state <= S_DIST; k <= '0; f <= '0; acc <= '0;
            best <= 5'h1f; best_d <= '0;
          end else begin
            di <= di + 3'd1; state <= S_DIV;
          end
        end
        S_DIST: begin
          if (f == 3'd7) begin
            if (acc_n < radius_sq(k) && (best[4] || acc_n < best_d)) begin
              best <= 5'(k); best_d <= acc_n;
            end
            acc <= '0; f <= '0;
            if (k == 4'(NumCent - 1)) state <= S_OUT;
            else k <= k + 4'd1;
          end else begin
            acc <= acc_n; f <= f + 3'd1;
          end
        end
        S_OUT: if (!out_ch.valid || out_ch.ready) begin
          if (emit) begin
            out_ch.data.action_class <= best[3:0];
            out_ch.data.destructive <= (best[3:0] == 4'd2 || best[3:0] == 4'd9 ||
                                        best[3:0] == 4'd10);
            out_ch.data.goal_index <= 4'(goals + GoalW'(1));
            goals <= last ? '0 : goals + GoalW'(1);
          end else if (last) goals <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // slots: 0 len, 1 vow, 2 con, 3 upper, 4 dig, 5 oth, 6 head, 7 tail
`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_goal_cap: assert property (@(posedge clk) disable iff (rst)
    goals < GoalW'(MaxGoals)) else $error("goal count overflow");
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.data.action_class < 4'(NumCent)) else $error("bad class");
`endif
endmodule
`default_nettype wire
